// File: hw/rtl/tcs_pkg.sv
// Shared types, opcodes and constants of the transmission coefficient sum core.
// No dependencies.
package tcs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int DIV_NW    = 32 + FRAC_BITS;   // dividend magnitude bits
    localparam int DIV_DW    = 33;               // divisor magnitude bits
    localparam int SQ_W      = 32 + FRAC_BITS;   // square root operand bits
    localparam int EMAX_W    = SQ_W / 2;
    localparam int TAYLOR_N  = 12;
    localparam int SQUARINGS = 5;

    // register indexes
    localparam logic [2:0] REG_C1      = 3'd0;
    localparam logic [2:0] REG_OFS_C   = 3'd1;
    localparam logic [2:0] REG_OFS_L   = 3'd2;
    localparam logic [2:0] REG_OFS_Q   = 3'd3;
    localparam logic [2:0] REG_INV_C   = 3'd4;
    localparam logic [2:0] REG_INV_L   = 3'd5;
    localparam logic [2:0] REG_INV_Q   = 3'd6;
    localparam logic [2:0] REG_E_SHIFT = 3'd7;

    typedef struct packed {
        logic               command;
        logic [5:0]         orbital_l;
        logic signed [31:0] kinetic_energy;
    } t_in;

    typedef struct packed {
        logic [24:0]        result_value;
        logic signed [31:0] exponent_term;
        logic               divide_fault;
    } t_out;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP      = 5'd0;
    localparam t_op OP_LOAD     = 5'd1;
    localparam t_op OP_C_A      = 5'd2;
    localparam t_op OP_C_B      = 5'd3;
    localparam t_op OP_DIV_Q    = 5'd4;
    localparam t_op OP_Q_WB     = 5'd5;
    localparam t_op OP_SQRT     = 5'd6;
    localparam t_op OP_EMAX     = 5'd7;
    localparam t_op OP_X_MAX    = 5'd8;
    localparam t_op OP_DIV_MIN  = 5'd9;
    localparam t_op OP_X_MIN    = 5'd10;
    localparam t_op OP_DIV_EN   = 5'd11;
    localparam t_op OP_X_EN     = 5'd12;
    localparam t_op OP_EXP_INIT = 5'd13;
    localparam t_op OP_TMUL     = 5'd14;
    localparam t_op OP_TDIV     = 5'd15;
    localparam t_op OP_TWB      = 5'd16;
    localparam t_op OP_CLAMP    = 5'd17;
    localparam t_op OP_SQ       = 5'd18;
    localparam t_op OP_DIV_T    = 5'd19;
    localparam t_op OP_T_WB     = 5'd20;
    localparam t_op OP_ACC      = 5'd21;
    localparam t_op OP_OUT      = 5'd22;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic c1_zero;
        logic q_pos;
        logic br_max;
        logic br_min;
        logic en_zero;
        logic exp_big;
        logic n_last;
        logic sq_last;
        logic cmd_sum;
        logic stop;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// File: hw/rtl/tcs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, sign applied at end.
// Depends on tcs_pkg.
module tcs_div
    import tcs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIV_NW-1:0]        i_dividend,
    input  logic [DIV_DW-1:0]        i_divisor,
    input  logic                     i_neg,
    output logic                     o_done,
    output logic signed [DIV_NW:0]   o_quot
);
    localparam int CW = $clog2(DIV_NW);

    logic              r_busy, r_done, r_neg;
    logic [CW-1:0]     r_cnt;
    logic [DIV_NW-1:0] r_dd;
    logic [DIV_DW-1:0] r_rem, r_dv;
    logic [DIV_DW:0]   w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_dd[DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dd  <= i_dividend;
            r_dv  <= i_divisor;
            r_neg <= i_neg;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_DW'(w_trial - {1'b0, r_dv}) : w_trial[DIV_DW-1:0];
            r_dd  <= {r_dd[DIV_NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_dd}) : $signed({1'b0, r_dd});

endmodule

// File: hw/rtl/tcs_sqrt.sv
// Bit-pair integer square root, floor result, one result bit per cycle.
// Depends on tcs_pkg.
module tcs_sqrt
    import tcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_val,
    output logic              o_done,
    output logic [EMAX_W-1:0] o_root
);
    logic            r_busy, r_done;
    logic [SQ_W-1:0] r_v, r_r, r_bit;
    logic [SQ_W-1:0] w_sum;

    assign w_sum = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if (r_v >= w_sum) begin
                r_v <= r_v - w_sum;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[EMAX_W-1:0];

endmodule

// File: hw/rtl/tcs_dpath.sv
// Datapath: coefficient registers, polynomial, exponent, exp series and sum.
// Depends on tcs_pkg, tcs_div, tcs_sqrt.
module tcs_dpath
    import tcs_pkg::*;
#(
    parameter int MAX_L = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_op                  i_op,
    input  t_in                  i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    output t_status              o_status,
    output t_out                 o_result
);
    localparam logic [31:0] Q31_ONE = 32'h8000_0000;

    logic signed [31:0] r_cfg [NUM_REGS];
    logic signed [31:0] r_en, r_c2, r_c3, r_x;
    logic               r_cmd, r_fault;
    logic [5:0]         r_k;
    logic signed [39:0] r_t2, r_t3;
    logic [30:0]        r_qs;
    logic               r_qpos, r_spos, r_sneg;
    logic [EMAX_W-1:0]  r_emax;
    logic [30:0]        r_r;
    logic [31:0]        r_term, r_p, r_v;
    logic signed [34:0] r_sum;
    logic [3:0]         r_n;
    logic [16:0]        r_t;
    logic [28:0]        r_tot;
    logic [23:0]        r_big;
    logic               r_stop;
    t_out               r_out;

    // cfg writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_cfg[i] <= '0;
        end else if (i_cfg_we && !i_cfg_idx[CFG_IDX_W-1]) begin
            r_cfg[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    // shared units
    logic                  w_div_start, w_div_done, w_div_neg, w_sq_done;
    logic [DIV_NW-1:0]     w_dd;
    logic [DIV_DW-1:0]     w_dv;
    logic signed [DIV_NW:0] w_quot;
    logic [EMAX_W-1:0]     w_root;

    logic signed [7:0]  w_fl;
    logic signed [39:0] w_pa2, w_pa3;
    logic signed [47:0] w_pb2, w_pb3;
    logic [31:0]        w_c3mag, w_c1mag, w_enmag, w_a;
    logic signed [63:0] w_cprod, w_xs;
    logic signed [32:0] w_mulb;
    logic signed [DIV_NW:0] w_qsel;
    logic [31:0]        w_ua, w_ub;
    logic [63:0]        w_uprod, w_sqr;
    logic [32:0]        w_den;
    logic [DIV_NW-1:0]  w_num;
    logic [23:0]        w_tw, w_bign;
    logic [30:0]        w_tw100;
    logic [28:0]        w_totn;

    assign w_fl    = $signed({2'b00, r_k}) + 8'sd1;
    assign w_pa2   = w_fl * r_cfg[REG_OFS_Q];
    assign w_pa3   = w_fl * r_cfg[REG_INV_Q];
    assign w_pb2   = w_fl * r_t2;
    assign w_pb3   = w_fl * r_t3;
    assign w_c3mag = r_c3[31] ? 32'(-r_c3) : r_c3;
    assign w_c1mag = r_cfg[REG_C1][31] ? 32'(-r_cfg[REG_C1]) : r_cfg[REG_C1];
    assign w_enmag = r_en[31] ? 32'(-r_en) : r_en;
    assign w_a     = r_x[31] ? 32'(-r_x) : r_x;

    assign w_mulb  = (i_op == OP_X_MIN) ? $signed({9'b0, r_emax}) : 33'(r_en);
    assign w_cprod = r_cfg[REG_C1] * w_mulb;
    always_comb begin
        if (i_op == OP_X_EN && r_en == 0) begin
            w_qsel = (r_c3 > 0) ? (DIV_NW+1)'(32'sh7FFFFFFF) :
                     (r_c3 < 0) ? (DIV_NW+1)'(32'sh80000000) : '0;
        end else begin
            w_qsel = w_quot;
        end
    end
    assign w_xs = (w_cprod >>> FRAC_BITS) + 64'(r_c2) + 64'(w_qsel);

    assign w_ua    = (i_op == OP_SQ) ? r_v : r_term;
    assign w_ub    = (i_op == OP_SQ) ? r_v : {1'b0, r_r};
    assign w_uprod = w_ua * w_ub;
    assign w_sqr   = w_uprod + 64'h4000_0000;

    assign w_den = {1'b0, Q31_ONE} + {1'b0, r_v};
    assign w_num = (DIV_NW'(r_x[31] ? Q31_ONE : r_v) << FRAC_BITS) + DIV_NW'(w_den >> 1);

    assign w_tw    = {r_k, 1'b1} * r_t;
    assign w_bign  = (w_tw > r_big) ? w_tw : r_big;
    assign w_tw100 = w_tw * 7'd100;
    assign w_totn  = r_tot + 29'(w_tw);

    // divider operand select
    always_comb begin
        w_div_start = 1'b0;
        w_dd        = DIV_NW'(w_c3mag) << FRAC_BITS;
        w_dv        = DIV_DW'(w_c1mag);
        w_div_neg   = 1'b0;
        unique case (i_op)
            OP_DIV_Q: begin
                w_div_start = 1'b1;
                w_div_neg   = r_c3[31] ^ r_cfg[REG_C1][31];
            end
            OP_DIV_MIN: begin
                w_div_start = 1'b1;
                w_dv        = DIV_DW'(r_emax);
                w_div_neg   = r_c3[31];
            end
            OP_DIV_EN: begin
                w_div_start = 1'b1;
                w_dv        = DIV_DW'(w_enmag);
                w_div_neg   = r_c3[31] ^ r_en[31];
            end
            OP_TDIV: begin
                w_div_start = 1'b1;
                w_dd        = DIV_NW'(r_p);
                w_dv        = DIV_DW'(r_n);
            end
            OP_DIV_T: begin
                w_div_start = 1'b1;
                w_dd        = w_num;
                w_dv        = w_den;
            end
            default: ;
        endcase
    end

    tcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dd),
        .i_divisor  (w_dv),
        .i_neg      (w_div_neg),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    tcs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_op == OP_SQRT),
        .i_val   (SQ_W'(r_qs) << FRAC_BITS),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_cmd   <= i_item.command;
                r_k     <= i_item.command ? 6'd0 : i_item.orbital_l;
                r_en    <= sat32(64'(i_item.kinetic_energy) + 64'(r_cfg[REG_E_SHIFT]));
                r_fault <= 1'b0;
                r_tot   <= '0;
                r_big   <= '0;
                r_stop  <= 1'b0;
            end
            OP_C_A: begin
                r_t2 <= w_pa2 + 40'(r_cfg[REG_OFS_L]);
                r_t3 <= w_pa3 + 40'(r_cfg[REG_INV_L]);
            end
            OP_C_B: begin
                r_c2   <= sat32(64'(w_pb2) + 64'(r_cfg[REG_OFS_C]));
                r_c3   <= sat32(64'(w_pb3) + 64'(r_cfg[REG_INV_C]));
                r_emax <= '0;
                r_spos <= 1'b0;
                r_sneg <= 1'b0;
                r_qpos <= 1'b0;
            end
            OP_Q_WB: begin
                r_qpos <= w_quot > 0;
                r_qs   <= (w_quot > (DIV_NW+1)'(32'sh7FFFFFFF)) ? '1 : w_quot[30:0];
                r_spos <= (w_quot > 0) && !r_c3[31];
                r_sneg <= (w_quot > 0) && r_c3[31];
            end
            OP_EMAX:  r_emax <= w_root;
            OP_X_MAX: r_x    <= 32'(100) <<< FRAC_BITS;
            OP_X_MIN: r_x    <= sat32(w_xs);
            OP_X_EN: begin
                r_x <= sat32(w_xs);
                if (r_en == 0) r_fault <= 1'b1;
            end
            OP_EXP_INIT: begin
                r_r    <= 31'(w_a << (26 - FRAC_BITS));
                r_term <= Q31_ONE;
                r_sum  <= 35'(Q31_ONE);
                r_n    <= 4'd1;
                r_v    <= '0;
            end
            OP_TMUL: r_p <= w_uprod[62:31];
            OP_TWB: begin
                r_term <= w_quot[31:0];
                r_sum  <= r_n[0] ? r_sum - $signed({3'b0, w_quot[31:0]})
                                 : r_sum + $signed({3'b0, w_quot[31:0]});
                r_n    <= r_n + 1'b1;
            end
            OP_CLAMP: begin
                if (r_sum < 0) r_v <= '0;
                else if (r_sum > 35'(Q31_ONE)) r_v <= Q31_ONE;
                else r_v <= r_sum[31:0];
                r_n <= '0;
            end
            OP_SQ: begin
                r_v <= w_sqr[62:31];
                r_n <= r_n + 1'b1;
            end
            OP_T_WB: r_t <= w_quot[16:0];
            OP_ACC: begin
                r_tot  <= w_totn;
                r_big  <= w_bign;
                r_stop <= (w_tw100 < 31'(w_bign)) || (r_k == 6'(MAX_L));
                r_k    <= r_k + 1'b1;
            end
            OP_OUT: begin
                if (r_cmd) begin
                    r_out.result_value <= (r_tot > 29'h1FFFFFF) ? '1 : r_tot[24:0];
                end else begin
                    r_out.result_value <= 25'(r_t);
                end
                r_out.exponent_term <= r_x;
                r_out.divide_fault  <= r_fault;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.div_done  = w_div_done;
        o_status.sqrt_done = w_sq_done;
        o_status.c1_zero   = r_cfg[REG_C1] == 0;
        o_status.q_pos     = r_qpos;
        o_status.br_max    = r_sneg && (33'(r_en) < $signed({9'b0, r_emax}));
        o_status.br_min    = r_spos && (33'(r_en) > $signed({9'b0, r_emax}));
        o_status.en_zero   = r_en == 0;
        o_status.exp_big   = w_a >= (32'd32 << FRAC_BITS);
        o_status.n_last    = r_n == 4'(TAYLOR_N);
        o_status.sq_last   = r_n == 4'(SQUARINGS - 1);
        o_status.cmd_sum   = r_cmd;
        o_status.stop      = r_stop;
    end

    assign o_result = r_out;

endmodule

// File: hw/rtl/tcs_ctrl.sv
// Sequencer: walks one item through the datapath steps, L by L in sum mode.
// Depends on tcs_pkg.
module tcs_ctrl
    import tcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_op     o_op,
    output logic    o_busy,
    output logic    o_strobe
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CA     = 5'd1;
    localparam logic [4:0] S_CB     = 5'd2;
    localparam logic [4:0] S_QCHK   = 5'd3;
    localparam logic [4:0] S_QWAIT  = 5'd4;
    localparam logic [4:0] S_QPOS   = 5'd5;
    localparam logic [4:0] S_SWAIT  = 5'd6;
    localparam logic [4:0] S_BR     = 5'd7;
    localparam logic [4:0] S_MWAIT  = 5'd8;
    localparam logic [4:0] S_EWAIT  = 5'd9;
    localparam logic [4:0] S_EXP    = 5'd10;
    localparam logic [4:0] S_EXPCHK = 5'd11;
    localparam logic [4:0] S_TMUL   = 5'd12;
    localparam logic [4:0] S_TDIVN  = 5'd13;
    localparam logic [4:0] S_TNWAIT = 5'd14;
    localparam logic [4:0] S_CLAMP  = 5'd15;
    localparam logic [4:0] S_SQ     = 5'd16;
    localparam logic [4:0] S_TDIV   = 5'd17;
    localparam logic [4:0] S_TWAIT  = 5'd18;
    localparam logic [4:0] S_ACC    = 5'd19;
    localparam logic [4:0] S_CHK    = 5'd20;

    logic [4:0] r_state, n_state;
    logic       r_strobe;
    t_op        w_op;

    always_comb begin
        n_state = r_state;
        w_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                w_op = OP_LOAD;  n_state = S_CA;
            end
            S_CA: begin
                w_op = OP_C_A;   n_state = S_CB;
            end
            S_CB: begin
                w_op = OP_C_B;   n_state = S_QCHK;
            end
            S_QCHK: begin
                if (i_status.c1_zero) n_state = S_BR;
                else begin
                    w_op = OP_DIV_Q; n_state = S_QWAIT;
                end
            end
            S_QWAIT: if (i_status.div_done) begin
                w_op = OP_Q_WB;  n_state = S_QPOS;
            end
            S_QPOS: begin
                if (i_status.q_pos) begin
                    w_op = OP_SQRT; n_state = S_SWAIT;
                end else n_state = S_BR;
            end
            S_SWAIT: if (i_status.sqrt_done) begin
                w_op = OP_EMAX;  n_state = S_BR;
            end
            S_BR: begin
                if (i_status.br_max) begin
                    w_op = OP_X_MAX;   n_state = S_EXP;
                end else if (i_status.br_min) begin
                    w_op = OP_DIV_MIN; n_state = S_MWAIT;
                end else if (i_status.en_zero) begin
                    w_op = OP_X_EN;    n_state = S_EXP;
                end else begin
                    w_op = OP_DIV_EN;  n_state = S_EWAIT;
                end
            end
            S_MWAIT: if (i_status.div_done) begin
                w_op = OP_X_MIN; n_state = S_EXP;
            end
            S_EWAIT: if (i_status.div_done) begin
                w_op = OP_X_EN;  n_state = S_EXP;
            end
            S_EXP: begin
                w_op = OP_EXP_INIT; n_state = S_EXPCHK;
            end
            S_EXPCHK: n_state = i_status.exp_big ? S_TDIV : S_TMUL;
            S_TMUL: begin
                w_op = OP_TMUL;  n_state = S_TDIVN;
            end
            S_TDIVN: begin
                w_op = OP_TDIV;  n_state = S_TNWAIT;
            end
            S_TNWAIT: if (i_status.div_done) begin
                w_op    = OP_TWB;
                n_state = i_status.n_last ? S_CLAMP : S_TMUL;
            end
            S_CLAMP: begin
                w_op = OP_CLAMP; n_state = S_SQ;
            end
            S_SQ: begin
                w_op = OP_SQ;
                if (i_status.sq_last) n_state = S_TDIV;
            end
            S_TDIV: begin
                w_op = OP_DIV_T; n_state = S_TWAIT;
            end
            S_TWAIT: if (i_status.div_done) begin
                w_op = OP_T_WB;  n_state = S_ACC;
            end
            S_ACC: begin
                if (i_status.cmd_sum) begin
                    w_op = OP_ACC; n_state = S_CHK;
                end else begin
                    w_op = OP_OUT; n_state = S_IDLE;
                end
            end
            S_CHK: begin
                if (i_status.stop) begin
                    w_op = OP_OUT; n_state = S_IDLE;
                end else n_state = S_CA;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_op == OP_OUT;
        end
    end

    assign o_op     = w_op;
    assign o_busy   = r_state != S_IDLE;
    assign o_strobe = r_strobe;

endmodule

// File: hw/rtl/transmission_coef_sum_core.sv
// Top level of the transmission coefficient core: controller plus datapath.
// Depends on tcs_pkg, tcs_ctrl, tcs_dpath.
//
// Usage: load the eight coefficient registers through the write port while
// idle, then raise start with an item while busy is low. Every transaction
// gives exactly one result, shown on o_result for one cycle with o_strobe;
// the receiver cannot stall it, so capture it on that cycle. A new item may
// be started in the cycle the strobe is high. One item is worked at a time.
// The shared bit-serial divider serves the stationary-point ratio, the
// C3/E or C3/Emax term, twelve series terms and the final 1/(1+e^x); a
// bit-serial square root gives Emax. Command 0 evaluates one L, and
// command 1 evaluates up to MAX_L+1 of them, fewer when the sum stops
// early. When the exponent is large the series is skipped.
// Register writes with an index of 8 or more are ignored.
module transmission_coef_sum_core
    import tcs_pkg::*;
#(
    parameter int MAX_L = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in                  i_item,
    output logic                 o_strobe,
    output t_out                 o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    t_op     w_op;
    t_status w_status;

    tcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_op     (w_op),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    tcs_dpath #(.MAX_L(MAX_L)) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_status   (w_status),
        .o_result   (o_result)
    );

    // a result is only presented once the sequencer is back to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction always keeps the core busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted transaction did not start");

    // never two result strobes in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("double result strobe");

endmodule
